>>> rtl/ltdc_pkg.sv
// Shared types, codes and constants of the light and time door controller.
`timescale 1ns / 1ps

package ltdc_pkg;

	// Field widths
	localparam int MODE_W   = 2;
	localparam int SAMPLE_W = 12;
	localparam int MINUTE_W = 11;
	localparam int ENC_W    = 21;
	localparam int LEVEL_W  = 8;
	localparam int OPENM_W  = 12;
	localparam int CFG_W    = 8;
	localparam int REG_IDX_W = 3;

	// Sum of three samples and the wider signed opening minute used internally
	localparam int SUM_W    = SAMPLE_W + 2;
	localparam int OPENI_W  = 13;

	// Default encoder counts per position unit
	localparam int unsigned COUNTS_PER_UNIT_DEF = 3000;

	// Light averaging: the samples are divided by their count and then by sixteen
	localparam int unsigned LIGHT_SAMPLES = 3;
	localparam int unsigned LIGHT_DIV = ((LIGHT_SAMPLES > 0) ? LIGHT_SAMPLES : 1) * 16;

	// Opening shift thresholds
	localparam logic [CFG_W-1:0] SHIFT_LATER_ABOVE   = 8'd125;
	localparam logic [CFG_W-1:0] SHIFT_EARLIER_BELOW = 8'd100;
	localparam logic [CFG_W-1:0] SHIFT_BASE          = 8'd100;

	// Input mode codes
	localparam logic [MODE_W-1:0] MODE_TICK        = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FORCE_OPEN  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FORCE_CLOSE = 2'd2;

	// Motor drive codes
	localparam logic [1:0] DRIVE_OFF   = 2'd0;
	localparam logic [1:0] DRIVE_OPEN  = 2'd1;
	localparam logic [1:0] DRIVE_CLOSE = 2'd2;

	// Door state codes
	localparam logic [1:0] DOOR_CLOSED  = 2'd0;
	localparam logic [1:0] DOOR_OPEN    = 2'd1;
	localparam logic [1:0] DOOR_BETWEEN = 2'd2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_LIGHT_UPPER  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LIGHT_LOWER  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_TOP_POSITION = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MINUTE_OFFSET = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_AUTOMATION   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LIGHT_ENABLE = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_TIME_ENABLE  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_TRACKING     = 3'd7;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_LIGHT_UPPER   = 8'd37;
	localparam logic [CFG_W-1:0] RST_LIGHT_LOWER   = 8'd25;
	localparam logic [CFG_W-1:0] RST_TOP_POSITION  = 8'd10;
	localparam logic [CFG_W-1:0] RST_MINUTE_OFFSET = 8'd0;

	typedef struct packed {
		logic [CFG_W-1:0] light_upper;
		logic [CFG_W-1:0] light_lower;
		logic [CFG_W-1:0] top_position;
		logic [CFG_W-1:0] minute_offset;
		logic             auto_enable;
		logic             light_enable;
		logic             window_enable;
		logic             position_tracking;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]        level;
		logic signed [OPENI_W-1:0] open_min;
		logic                      day;
	} front_t;

	typedef struct packed {
		logic [1:0]         drive;
		logic [1:0]         door_state;
		logic [CFG_W-1:0]   position;
		logic               finished;
		logic               stall;
	} door_res_t;

endpackage

>>> rtl/ltdc_cdiv.sv
// Division of an unsigned value by a constant through a reciprocal multiply.
`timescale 1ns / 1ps

module ltdc_cdiv
	import ltdc_pkg::*;
#(
	parameter int          NUM_W   = 20,
	parameter int unsigned DIVISOR = COUNTS_PER_UNIT_DEF
) (
	input  logic [NUM_W-1:0] num,
	output logic [NUM_W-1:0] quot
);

	// Exact for every numerator below 2**NUM_W: multiplier = ceil(2**(N+L) / d)
	localparam int              L_W    = $clog2(DIVISOR);
	localparam int              SHIFT  = NUM_W + L_W;
	localparam int              M_W    = NUM_W + 2;
	localparam int              PROD_W = NUM_W + M_W + L_W;
	localparam longint unsigned RECIP  =
		((64'd1 << SHIFT) + longint'(DIVISOR) - 64'd1) / longint'(DIVISOR);

	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(num) * PROD_W'(M_W'(RECIP));
	assign quot = prod[SHIFT +: NUM_W];

endmodule

>>> rtl/ltdc_front.sv
// Light level averaging, opening minute shift and day window test.
`timescale 1ns / 1ps

module ltdc_front
	import ltdc_pkg::*;
(
	input  logic [SAMPLE_W-1:0] light_a,
	input  logic [SAMPLE_W-1:0] light_b,
	input  logic [SAMPLE_W-1:0] light_c,
	input  logic [MINUTE_W-1:0] now,
	input  logic [MINUTE_W-1:0] sunrise,
	input  logic [MINUTE_W-1:0] sunset,
	input  logic [CFG_W-1:0]    minute_offset,
	output front_t              res
);

	logic [SUM_W-1:0]   sum;
	logic [SUM_W-1:0]   avg;
	logic [OPENI_W-1:0] base;
	logic [OPENI_W-1:0] later;
	logic [OPENI_W-1:0] earlier;
	logic [OPENI_W-1:0] open_u;

	assign sum = SUM_W'(light_a) + SUM_W'(light_b) + SUM_W'(light_c);

	ltdc_cdiv #(
		.NUM_W   (SUM_W),
		.DIVISOR (LIGHT_DIV)
	) u_level_div (
		.num  (sum),
		.quot (avg)
	);

	// Saturate the level at full scale
	assign res.level = (avg > SUM_W'(8'hFF)) ? 8'hFF : avg[LEVEL_W-1:0];

	// Shift sunrise: two minutes per code step
	assign base    = OPENI_W'(sunrise);
	assign later   = OPENI_W'({minute_offset - SHIFT_BASE, 1'b0});
	assign earlier = OPENI_W'({minute_offset, 1'b0});

	always_comb begin
		if (minute_offset > SHIFT_LATER_ABOVE) begin
			open_u = base + later;
		end else if (minute_offset < SHIFT_EARLIER_BELOW) begin
			open_u = base - earlier;
		end else begin
			open_u = base;
		end
	end

	assign res.open_min = $signed(open_u);
	assign res.day = ($signed(open_u) <= $signed(OPENI_W'(now))) && (now <= sunset);

endmodule

>>> rtl/ltdc_door.sv
// Door motion state, start decision and move completion.
`timescale 1ns / 1ps

module ltdc_door
	import ltdc_pkg::*;
#(
	parameter int unsigned COUNTS_PER_UNIT = COUNTS_PER_UNIT_DEF,
	parameter int          TC_W            = CFG_W + $clog2(COUNTS_PER_UNIT + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  cfg_t                    cfg,
	input  logic [TC_W-1:0]         top_counts,
	input  logic [MODE_W-1:0]       mode,
	input  logic signed [ENC_W-1:0] enc,
	input  logic                    tvalid,
	input  front_t                  front,
	output door_res_t               res
);

	typedef enum logic [2:0] {
		MOT_IDLE    = 3'b001,
		MOT_OPENING = 3'b010,
		MOT_CLOSING = 3'b100
	} motion_t;

	localparam int CMP_W = (TC_W > ENC_W - 1) ? TC_W : ENC_W - 1;

	motion_t            mot_q, mot_d, run_mot;
	logic [CFG_W-1:0]   pos_q, pos_d, enc_pos;
	logic               closed_q, closed_d;
	logic [ENC_W-1:0]   prev_q, prev_d;
	logic [ENC_W-2:0]   enc_quot;
	logic               enc_ge_top, enc_le_zero;
	logic [1:0]         ds_now;
	logic               gate, tday, tnight, dark, bright;
	logic               start_open, start_close;
	logic               run, check, reached, stall, finished;

	function automatic logic [1:0] door_state_of(input logic tracking,
		input logic [CFG_W-1:0] pos, input logic [CFG_W-1:0] top, input logic closed);
		logic [1:0] ds;
		if (tracking) begin
			if (pos == '0) begin
				ds = DOOR_CLOSED;
			end else if (pos == top) begin
				ds = DOOR_OPEN;
			end else begin
				ds = DOOR_BETWEEN;
			end
		end else begin
			ds = closed ? DOOR_CLOSED : DOOR_OPEN;
		end
		return ds;
	endfunction

	// Encoder against the two ends
	assign enc_le_zero = enc[ENC_W-1] || (enc == '0);
	assign enc_ge_top  = !enc[ENC_W-1] &&
		(CMP_W'(enc[ENC_W-2:0]) >= CMP_W'(top_counts));

	ltdc_cdiv #(
		.NUM_W   (ENC_W - 1),
		.DIVISOR (COUNTS_PER_UNIT)
	) u_pos_div (
		.num  (enc[ENC_W-2:0]),
		.quot (enc_quot)
	);

	// Position while moving: zero for non-positive counts, capped at top
	always_comb begin
		if (enc_le_zero) begin
			enc_pos = '0;
		end else if (enc_quot > (ENC_W-1)'(cfg.top_position)) begin
			enc_pos = cfg.top_position;
		end else begin
			enc_pos = enc_quot[CFG_W-1:0];
		end
	end

	// Start decision on an idle tick
	assign ds_now = door_state_of(cfg.position_tracking, pos_q, cfg.top_position, closed_q);
	assign gate   = cfg.auto_enable && (cfg.light_enable || cfg.window_enable);
	assign tday   = tvalid ? front.day : cfg.light_enable;
	assign tnight = tvalid ? !front.day : cfg.light_enable;
	assign dark   = !cfg.light_enable || (front.level <= cfg.light_lower);
	assign bright = !cfg.light_enable || (front.level >= cfg.light_upper);

	assign start_close = (ds_now == DOOR_BETWEEN) ||
		(gate && (ds_now == DOOR_OPEN) && dark && (!cfg.window_enable || tnight));
	assign start_open  = (ds_now == DOOR_CLOSED) && gate && bright &&
		(!cfg.window_enable || tday);

	always_comb begin
		mot_d    = mot_q;
		pos_d    = pos_q;
		closed_d = closed_q;
		prev_d   = prev_q;
		run      = 1'b0;
		check    = 1'b0;
		run_mot  = mot_q;
		reached  = 1'b0;
		stall    = 1'b0;
		finished = 1'b0;
		case (mode)
			MODE_FORCE_OPEN: begin
				mot_d    = MOT_IDLE;
				closed_d = 1'b0;
				pos_d    = cfg.top_position;
				prev_d   = ENC_W'(top_counts);
			end
			MODE_FORCE_CLOSE: begin
				mot_d    = MOT_IDLE;
				closed_d = 1'b1;
				pos_d    = '0;
				prev_d   = '0;
			end
			default: begin
				prev_d = enc;
				if (mot_q != MOT_IDLE) begin
					run   = 1'b1;
					check = 1'b1;
				end else if (start_close) begin
					run     = 1'b1;
					run_mot = MOT_CLOSING;
				end else if (start_open) begin
					run     = 1'b1;
					run_mot = MOT_OPENING;
				end
				if (run) begin
					reached = (run_mot == MOT_OPENING) ? enc_ge_top : enc_le_zero;
					stall   = !reached && !cfg.position_tracking && check && (enc == prev_q);
					if (reached || stall) begin
						finished = 1'b1;
						mot_d    = MOT_IDLE;
						if (cfg.position_tracking) begin
							pos_d = (run_mot == MOT_OPENING) ? cfg.top_position : '0;
						end else begin
							closed_d = !closed_q;
						end
					end else begin
						mot_d = run_mot;
						if (cfg.position_tracking) begin
							pos_d = enc_pos;
						end
					end
				end
			end
		endcase
	end

	always_comb begin
		case (mot_d)
			MOT_OPENING: res.drive = DRIVE_OPEN;
			MOT_CLOSING: res.drive = DRIVE_CLOSE;
			default:     res.drive = DRIVE_OFF;
		endcase
	end

	assign res.door_state = door_state_of(cfg.position_tracking, pos_d, cfg.top_position,
		closed_d);
	assign res.position   = (pos_d > cfg.top_position) ? cfg.top_position : pos_d;
	assign res.finished   = finished;
	assign res.stall      = stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mot_q    <= MOT_IDLE;
			pos_q    <= '0;
			closed_q <= 1'b1;
			prev_q   <= '0;
		end else if (step) begin
			mot_q    <= mot_d;
			pos_q    <= pos_d;
			closed_q <= closed_d;
			prev_q   <= prev_d;
		end
	end

endmodule

>>> rtl/light_time_door_controller.sv
// Top level of the light and time door controller: registers, handshakes and result stage.
// An item taken in passes the input register and then the result register, from which it is offered.
// Throughput: one item per cycle while out_ready is high; the input register refills while the result register drains.
// The single compute stage between the two registers reads and updates the door state.
// Reset (arst_n low, asynchronous) empties both stages, idles the door with position zero and
// the closed flag set, and loads every configuration register with its reset value.
`timescale 1ns / 1ps

module light_time_door_controller
	import ltdc_pkg::*;
#(
	parameter int unsigned COUNTS_PER_UNIT = COUNTS_PER_UNIT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// input channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [MODE_W-1:0]       mode,
	input  logic [SAMPLE_W-1:0]     light_sample_a,
	input  logic [SAMPLE_W-1:0]     light_sample_b,
	input  logic [SAMPLE_W-1:0]     light_sample_c,
	input  logic [MINUTE_W-1:0]     minute_of_day,
	input  logic                    time_valid,
	input  logic [MINUTE_W-1:0]     sunrise_minute,
	input  logic [MINUTE_W-1:0]     sunset_minute,
	input  logic signed [ENC_W-1:0] encoder_count,
	// result channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              motor_drive,
	output logic [1:0]              door_state,
	output logic [CFG_W-1:0]        door_position,
	output logic                    move_finished,
	output logic                    stalled,
	output logic [LEVEL_W-1:0]      light_level,
	output logic signed [OPENM_W-1:0] open_minute,
	// configuration channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [REG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam int TC_W = CFG_W + $clog2(COUNTS_PER_UNIT + 1);

	// Configuration registers, plus the open-end count kept alongside top_position
	cfg_t             cfg_q;
	logic [TC_W-1:0]  top_counts_q;

	// Input stage
	logic                    valid_s1;
	logic [MODE_W-1:0]       mode_s1;
	logic [SAMPLE_W-1:0]     light_a_s1, light_b_s1, light_c_s1;
	logic [MINUTE_W-1:0]     now_s1, sunrise_s1, sunset_s1;
	logic                    tvalid_s1;
	logic signed [ENC_W-1:0] enc_s1;

	// Result stage
	logic                      out_valid_q;
	logic [1:0]                drive_q, door_state_q;
	logic [CFG_W-1:0]          position_q;
	logic                      finished_q, stall_q;
	logic [LEVEL_W-1:0]        level_q;
	logic [OPENM_W-1:0]        open_min_q;

	logic      advance;
	front_t    front;
	door_res_t door_res;

	// The stage moves on whenever the result register is free or being emptied
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Configuration writes: take every transfer, update the open-end count with top_position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light_upper       <= RST_LIGHT_UPPER;
			cfg_q.light_lower       <= RST_LIGHT_LOWER;
			cfg_q.top_position      <= RST_TOP_POSITION;
			cfg_q.minute_offset     <= RST_MINUTE_OFFSET;
			cfg_q.auto_enable       <= 1'b1;
			cfg_q.light_enable      <= 1'b0;
			cfg_q.window_enable     <= 1'b1;
			cfg_q.position_tracking <= 1'b1;
			top_counts_q            <= TC_W'(RST_TOP_POSITION) * TC_W'(COUNTS_PER_UNIT);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LIGHT_UPPER:   cfg_q.light_upper   <= cfg_data;
				REG_LIGHT_LOWER:   cfg_q.light_lower   <= cfg_data;
				REG_TOP_POSITION: begin
					cfg_q.top_position <= cfg_data;
					top_counts_q       <= TC_W'(cfg_data) * TC_W'(COUNTS_PER_UNIT);
				end
				REG_MINUTE_OFFSET: cfg_q.minute_offset <= cfg_data;
				REG_AUTOMATION:    cfg_q.auto_enable       <= cfg_data[0];
				REG_LIGHT_ENABLE:  cfg_q.light_enable      <= cfg_data[0];
				REG_TIME_ENABLE:   cfg_q.window_enable     <= cfg_data[0];
				REG_TRACKING:      cfg_q.position_tracking <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input stage: hold the item until the compute stage can hand it on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1    <= mode;
			light_a_s1 <= light_sample_a;
			light_b_s1 <= light_sample_b;
			light_c_s1 <= light_sample_c;
			now_s1     <= minute_of_day;
			tvalid_s1  <= time_valid;
			sunrise_s1 <= sunrise_minute;
			sunset_s1  <= sunset_minute;
			enc_s1     <= encoder_count;
		end
	end

	// Light level, shifted opening minute and the day window
	ltdc_front u_front (
		.light_a       (light_a_s1),
		.light_b       (light_b_s1),
		.light_c       (light_c_s1),
		.now           (now_s1),
		.sunrise       (sunrise_s1),
		.sunset        (sunset_s1),
		.minute_offset (cfg_q.minute_offset),
		.res           (front)
	);

	// Door state: updated only when the item advances into the result register
	ltdc_door #(
		.COUNTS_PER_UNIT (COUNTS_PER_UNIT),
		.TC_W            (TC_W)
	) u_door (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.cfg        (cfg_q),
		.top_counts (top_counts_q),
		.mode       (mode_s1),
		.enc        (enc_s1),
		.tvalid     (tvalid_s1),
		.front      (front),
		.res        (door_res)
	);

	// Result stage: drop the valid flag after the transfer unless a new item arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q      <= door_res.drive;
			door_state_q <= door_res.door_state;
			position_q   <= door_res.position;
			finished_q   <= door_res.finished;
			stall_q      <= door_res.stall;
			level_q      <= front.level;
			open_min_q   <= front.open_min[OPENM_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign motor_drive   = drive_q;
	assign door_state    = door_state_q;
	assign door_position = position_q;
	assign move_finished = finished_q;
	assign stalled       = stall_q;
	assign light_level   = level_q;
	assign open_minute   = $signed(open_min_q);

	// A finished move leaves the motor off
	a_finish_stops_motor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && finished_q |-> drive_q == DRIVE_OFF)
		else $error("move finished with motor still driven");

	// A stall always ends the move, and only happens without position tracking
	a_stall_ends_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && stall_q |-> finished_q && !cfg_q.position_tracking)
		else $error("stall without move end or with tracking on");

	// The reported position never exceeds the open end
	a_position_capped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> position_q <= cfg_q.top_position)
		else $error("door position beyond top");

	// An empty result register never holds back the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result register");

	// An item in the input stage reaches the result register in the next cycle when free
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced item not presented");

endmodule

>>> bench/ltdc_door_checker.sv
// Checker for the door controller: tracks the door and compares every result transfer.
`timescale 1ns / 1ps

module ltdc_door_checker
	import ltdc_pkg::*;
#(
	parameter int unsigned COUNTS_PER_UNIT = COUNTS_PER_UNIT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [MODE_W-1:0]         mode,
	input  logic [SAMPLE_W-1:0]       light_sample_a,
	input  logic [SAMPLE_W-1:0]       light_sample_b,
	input  logic [SAMPLE_W-1:0]       light_sample_c,
	input  logic [MINUTE_W-1:0]       minute_of_day,
	input  logic                      time_valid,
	input  logic [MINUTE_W-1:0]       sunrise_minute,
	input  logic [MINUTE_W-1:0]       sunset_minute,
	input  logic signed [ENC_W-1:0]   encoder_count,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [1:0]                motor_drive,
	input  logic [1:0]                door_state,
	input  logic [CFG_W-1:0]          door_position,
	input  logic                      move_finished,
	input  logic                      stalled,
	input  logic [LEVEL_W-1:0]        light_level,
	input  logic signed [OPENM_W-1:0] open_minute,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [REG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	output int                        error_count,
	output int                        results_due,
	output int                        ticks_checked,
	output int                        moves_finished,
	output int                        stalls_seen
);

	localparam int SAMPLE_COUNT    = 3;
	localparam int LEVEL_SCALE     = 16;
	localparam int LEVEL_MAX       = 255;
	localparam int OFFSET_LATER    = 125;
	localparam int OFFSET_EARLIER  = 100;
	localparam int OFFSET_BASE     = 100;

	typedef struct packed {
		logic [1:0]                drive;
		logic [1:0]                state;
		logic [CFG_W-1:0]          position;
		logic                      finished;
		logic                      stall;
		logic [LEVEL_W-1:0]        level;
		logic signed [OPENM_W-1:0] open_min;
	} door_result_t;

	cfg_t             cfg;
	logic [CFG_W-1:0] pos;
	logic             shut;
	logic [1:0]       motion;
	int               last_enc;
	door_result_t     door_results_due[$];
	int               mismatches = 0;
	int               checked = 0;
	int               finishes = 0;
	int               stalls = 0;

	assign error_count    = mismatches;
	assign ticks_checked  = checked;
	assign moves_finished = finishes;
	assign stalls_seen    = stalls;

	function automatic logic [1:0] door_now();
		if (cfg.position_tracking) begin
			if (pos == '0)
				return DOOR_CLOSED;
			if (pos == cfg.top_position)
				return DOOR_OPEN;
			return DOOR_BETWEEN;
		end
		return shut ? DOOR_CLOSED : DOOR_OPEN;
	endfunction

	function automatic logic [CFG_W-1:0] units_from_count(int enc);
		int p;
		if (enc <= 0)
			return '0;
		p = enc / int'(COUNTS_PER_UNIT);
		if (p > int'(cfg.top_position))
			p = int'(cfg.top_position);
		return p[CFG_W-1:0];
	endfunction

	// Evaluate the running move; true when it ended on this tick.
	function automatic bit follow_move(int enc, bit watch_stall, output bit stall);
		int top_count;
		bit reached;
		top_count = int'(cfg.top_position) * int'(COUNTS_PER_UNIT);
		reached = (motion == DRIVE_OPEN) ? (enc >= top_count) : (enc <= 0);
		stall = 1'b0;
		// an encoder that did not move since the last tick ends an untracked move
		if (!reached && !cfg.position_tracking && watch_stall && enc == last_enc) begin
			stall = 1'b1;
			reached = 1'b1;
		end
		if (!reached) begin
			if (cfg.position_tracking)
				pos = units_from_count(enc);
			return 1'b0;
		end
		if (cfg.position_tracking)
			pos = (motion == DRIVE_OPEN) ? cfg.top_position : '0;
		else
			shut = !shut;
		motion = DRIVE_OFF;
		return 1'b1;
	endfunction

	function automatic door_result_t step_door(
		input logic [MODE_W-1:0]       mode_in,
		input logic [SAMPLE_W-1:0]     sa,
		input logic [SAMPLE_W-1:0]     sb,
		input logic [SAMPLE_W-1:0]     sc,
		input logic [MINUTE_W-1:0]     clock_min,
		input logic                    tv,
		input logic [MINUTE_W-1:0]     dawn,
		input logic [MINUTE_W-1:0]     dusk,
		input logic signed [ENC_W-1:0] enc_in
	);
		door_result_t r;
		int lvl, open_m, enc;
		bit finished, stall, is_day, t_day, t_night, dark, bright, bed, wake;
		logic [1:0] ds, start;
		lvl = (int'(sa) + int'(sb) + int'(sc)) / SAMPLE_COUNT / LEVEL_SCALE;
		if (lvl > LEVEL_MAX)
			lvl = LEVEL_MAX;
		if (int'(cfg.minute_offset) > OFFSET_LATER)
			open_m = int'(dawn) + (int'(cfg.minute_offset) - OFFSET_BASE) * 2;
		else if (int'(cfg.minute_offset) < OFFSET_EARLIER)
			open_m = int'(dawn) - int'(cfg.minute_offset) * 2;
		else
			open_m = int'(dawn);
		enc = int'(enc_in);
		finished = 1'b0;
		stall = 1'b0;
		if (mode_in == MODE_FORCE_OPEN || mode_in == MODE_FORCE_CLOSE) begin
			// forced end position: cancel any move, no decision this tick
			motion = DRIVE_OFF;
			if (mode_in == MODE_FORCE_OPEN) begin
				shut = 1'b0;
				pos = cfg.top_position;
				last_enc = int'(cfg.top_position) * int'(COUNTS_PER_UNIT);
			end else begin
				shut = 1'b1;
				pos = '0;
				last_enc = 0;
			end
		end else begin
			if (motion != DRIVE_OFF) begin
				finished = follow_move(enc, 1'b1, stall);
			end else begin
				ds = door_now();
				start = DRIVE_OFF;
				if (ds == DOOR_BETWEEN) begin
					start = DRIVE_CLOSE;
				end else if (cfg.auto_enable && (cfg.light_enable || cfg.window_enable)) begin
					is_day = (open_m <= int'(clock_min)) && (int'(clock_min) <= int'(dusk));
					// unknown time of day answers with the light-sensor enable
					t_day = tv ? is_day : cfg.light_enable;
					t_night = tv ? !is_day : cfg.light_enable;
					if (ds == DOOR_OPEN) begin
						dark = !cfg.light_enable || lvl <= int'(cfg.light_lower);
						bed = !cfg.window_enable || t_night;
						if (dark && bed)
							start = DRIVE_CLOSE;
					end else begin
						bright = !cfg.light_enable || lvl >= int'(cfg.light_upper);
						wake = !cfg.window_enable || t_day;
						if (bright && wake)
							start = DRIVE_OPEN;
					end
				end
				if (start != DRIVE_OFF) begin
					motion = start;
					finished = follow_move(enc, 1'b0, stall);
				end
			end
			last_enc = enc;
		end
		r.drive = motion;
		r.state = door_now();
		r.position = (pos > cfg.top_position) ? cfg.top_position : pos;
		r.finished = finished;
		r.stall = stall;
		r.level = lvl[LEVEL_W-1:0];
		r.open_min = open_m[OPENM_W-1:0];
		return r;
	endfunction

	function automatic void compare_field(string field, logic signed [31:0] want,
		logic signed [31:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0d, actual %0d", field, want, seen);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		door_result_t want;
		if (!arst_n) begin
			cfg.light_upper = RST_LIGHT_UPPER;
			cfg.light_lower = RST_LIGHT_LOWER;
			cfg.top_position = RST_TOP_POSITION;
			cfg.minute_offset = RST_MINUTE_OFFSET;
			cfg.auto_enable = 1'b1;
			cfg.light_enable = 1'b0;
			cfg.window_enable = 1'b1;
			cfg.position_tracking = 1'b1;
			pos = '0;
			shut = 1'b1;
			motion = DRIVE_OFF;
			last_enc = 0;
			door_results_due.delete();
		end else begin
			// results first: a result never stems from the input taken on the same edge
			if (out_valid && out_ready) begin
				if (door_results_due.size() == 0) begin
					$error("result transfer with no result awaited");
					mismatches++;
				end else begin
					want = door_results_due.pop_front();
					checked++;
					finishes += int'(want.finished);
					stalls += int'(want.stall);
					compare_field("motor_drive", 32'(want.drive), 32'(motor_drive));
					compare_field("door_state", 32'(want.state), 32'(door_state));
					compare_field("door_position", 32'(want.position), 32'(door_position));
					compare_field("move_finished", 32'(want.finished), 32'(move_finished));
					compare_field("stalled", 32'(want.stall), 32'(stalled));
					compare_field("light_level", 32'(want.level), 32'(light_level));
					compare_field("open_minute", 32'(want.open_min), 32'(open_minute));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LIGHT_UPPER:   cfg.light_upper = cfg_data;
					REG_LIGHT_LOWER:   cfg.light_lower = cfg_data;
					REG_TOP_POSITION:  cfg.top_position = cfg_data;
					REG_MINUTE_OFFSET: cfg.minute_offset = cfg_data;
					REG_AUTOMATION:    cfg.auto_enable = cfg_data[0];
					REG_LIGHT_ENABLE:  cfg.light_enable = cfg_data[0];
					REG_TIME_ENABLE:   cfg.window_enable = cfg_data[0];
					REG_TRACKING:      cfg.position_tracking = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				door_results_due.push_back(step_door(mode, light_sample_a, light_sample_b,
					light_sample_c, minute_of_day, time_valid, sunrise_minute, sunset_minute,
					encoder_count));
		end
		results_due = door_results_due.size();
	end

endmodule

>>> bench/light_time_door_controller_test.sv
// Top of the door controller bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module light_time_door_controller_test;
	import ltdc_pkg::*;

	// the spare mode code behaves as an ordinary tick
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam int COUNTS = COUNTS_PER_UNIT_DEF;
	localparam int PHASES = 12;
	localparam int TICKS_PER_PHASE = 75;

	typedef struct {
		logic [MODE_W-1:0]       mode;
		logic [SAMPLE_W-1:0]     a;
		logic [SAMPLE_W-1:0]     b;
		logic [SAMPLE_W-1:0]     c;
		logic [MINUTE_W-1:0]     minute;
		logic                    tvalid;
		logic [MINUTE_W-1:0]     dawn;
		logic [MINUTE_W-1:0]     dusk;
		logic signed [ENC_W-1:0] enc;
	} tick_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [MODE_W-1:0]         mode = MODE_TICK;
	logic [SAMPLE_W-1:0]       light_sample_a = '0;
	logic [SAMPLE_W-1:0]       light_sample_b = '0;
	logic [SAMPLE_W-1:0]       light_sample_c = '0;
	logic [MINUTE_W-1:0]       minute_of_day = '0;
	logic                      time_valid = 1'b0;
	logic [MINUTE_W-1:0]       sunrise_minute = '0;
	logic [MINUTE_W-1:0]       sunset_minute = '0;
	logic signed [ENC_W-1:0]   encoder_count = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [1:0]                motor_drive;
	logic [1:0]                door_state;
	logic [CFG_W-1:0]          door_position;
	logic                      move_finished;
	logic                      stalled;
	logic [LEVEL_W-1:0]        light_level;
	logic signed [OPENM_W-1:0] open_minute;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [REG_IDX_W-1:0]      cfg_index = REG_LIGHT_UPPER;
	logic [CFG_W-1:0]          cfg_data = '0;

	int error_count;
	int results_due;
	int ticks_checked;
	int moves_finished;
	int stalls_seen;

	// stimulus state: a gap-free stretch flag, the current top and the walks
	bit calm = 1'b0;
	int top_now = int'(RST_TOP_POSITION);
	int enc_walk = 0;
	bit heading = 1'b1;
	int clock_min = 0;
	int reg_writes = 0;
	int settings_run = 1;

	light_time_door_controller dut (.*);
	ltdc_door_checker checker_i (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hold the run to a fixed budget, far above the slowest correct run.
	initial begin
		#4_000_000;
		$display("light_time_door_controller regression: fail");
		$finish;
	end

	// Result side: stall each transfer at random, never in a calm stretch.
	initial begin
		int stall_len;
		wait (arst_n);
		forever begin
			stall_len = calm ? 0 : $urandom_range(0, 4);
			@(negedge clk);
			if (stall_len > 0) begin
				out_ready = 1'b0;
				repeat (stall_len) @(negedge clk);
			end
			out_ready = 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	function automatic tick_t tick_of(logic [MODE_W-1:0] m, int sa, int sb, int sc, int mn,
		bit tv, int dawn, int dusk, logic signed [ENC_W-1:0] enc);
		tick_t t;
		t.mode = m;
		t.a = sa[SAMPLE_W-1:0];
		t.b = sb[SAMPLE_W-1:0];
		t.c = sc[SAMPLE_W-1:0];
		t.minute = mn[MINUTE_W-1:0];
		t.tvalid = tv;
		t.dawn = dawn[MINUTE_W-1:0];
		t.dusk = dusk[MINUTE_W-1:0];
		t.enc = enc;
		return t;
	endfunction

	// Draw a plausible tick: the encoder walks between the ends, the clock moves on,
	// and the light follows the hour; now and then a field is thrown anywhere.
	function automatic tick_t roll_tick();
		tick_t t;
		int span, r, band_lo, band_hi;
		logic signed [ENC_W-1:0] wild;
		span = (top_now == 0 ? 1 : top_now) * COUNTS;
		r = $urandom_range(0, 99);
		t.mode = (r < 88) ? MODE_TICK : (r < 93) ? MODE_FORCE_OPEN :
			(r < 98) ? MODE_FORCE_CLOSE : MODE_SPARE;
		if ($urandom_range(0, 9) == 0)
			heading = !heading;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			wild = ENC_W'($urandom);
			enc_walk = int'(wild);
		end else if (r >= 4) begin
			if (enc_walk < -COUNTS || enc_walk > span + COUNTS)
				enc_walk = heading ? 0 : span;
			enc_walk += heading ? $urandom_range(1, span / 2 + 1) : -$urandom_range(1, span / 2 + 1);
			if (enc_walk > span + COUNTS) begin
				enc_walk = span + COUNTS;
				heading = 1'b0;
			end else if (enc_walk < -COUNTS) begin
				enc_walk = -COUNTS;
				heading = 1'b1;
			end
		end
		t.enc = ENC_W'(enc_walk);
		if (t.mode == MODE_FORCE_OPEN)
			enc_walk = span;
		else if (t.mode == MODE_FORCE_CLOSE)
			enc_walk = 0;
		clock_min = (clock_min + $urandom_range(0, 90)) % 1440;
		t.minute = MINUTE_W'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 2047) : clock_min);
		t.tvalid = ($urandom_range(0, 9) != 0);
		if ($urandom_range(0, 19) == 0) begin
			t.dawn = MINUTE_W'($urandom_range(0, 2047));
			t.dusk = MINUTE_W'($urandom_range(0, 2047));
		end else begin
			t.dawn = MINUTE_W'(300 + $urandom_range(0, 200));
			t.dusk = MINUTE_W'(1000 + $urandom_range(0, 250));
		end
		if (clock_min >= 420 && clock_min <= 1080) begin
			band_lo = 1200;
			band_hi = 4095;
		end else begin
			band_lo = 0;
			band_hi = 1500;
		end
		if ($urandom_range(0, 9) == 0) begin
			band_lo = 0;
			band_hi = 4095;
		end
		t.a = SAMPLE_W'($urandom_range(band_lo, band_hi));
		t.b = SAMPLE_W'($urandom_range(band_lo, band_hi));
		t.c = SAMPLE_W'($urandom_range(band_lo, band_hi));
		return t;
	endfunction

	// Offer one tick after a random gap and hold it until the transfer.
	task automatic drive_tick(input tick_t t);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode = t.mode;
		light_sample_a = t.a;
		light_sample_b = t.b;
		light_sample_c = t.c;
		minute_of_day = t.minute;
		time_valid = t.tvalid;
		sunrise_minute = t.dawn;
		sunset_minute = t.dusk;
		encoder_count = t.enc;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drop the input and wait until every awaited result has been checked.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		wait (results_due == 0);
	endtask

	// Drain, then let the two pipeline stages run dry before touching a register.
	task automatic settle();
		drain();
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = value[CFG_W-1:0];
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		reg_writes++;
		if (idx == REG_TOP_POSITION)
			top_now = value & 8'hFF;
	endtask

	task automatic apply_setting(input int upper, input int lower, input int top, input int offset,
		input bit automate, input bit use_light, input bit use_time, input bit track);
		write_reg(REG_LIGHT_UPPER, upper);
		write_reg(REG_LIGHT_LOWER, lower);
		write_reg(REG_TOP_POSITION, top);
		write_reg(REG_MINUTE_OFFSET, offset);
		write_reg(REG_AUTOMATION, int'(automate));
		write_reg(REG_LIGHT_ENABLE, int'(use_light));
		write_reg(REG_TIME_ENABLE, int'(use_time));
		write_reg(REG_TRACKING, int'(track));
	endtask

	// Pick a register value, biased towards its ends.
	function automatic int pick_byte();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 0;
		if (r == 1)
			return 255;
		return $urandom_range(0, 255);
	endfunction

	initial begin
		int phase, k;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset settings, a full open and close by time of day
		calm = 1'b1;
		drive_tick(tick_of(MODE_TICK, 1000, 1000, 1000, 600, 1, 360, 1080, 0));
		drive_tick(tick_of(MODE_TICK, 1000, 1000, 1000, 605, 1, 360, 1080, 15000));
		drive_tick(tick_of(MODE_TICK, 1000, 1000, 1000, 610, 1, 360, 1080, 30000));
		drive_tick(tick_of(MODE_TICK, 1000, 1000, 1000, 700, 1, 360, 1080, 30000));
		drive_tick(tick_of(MODE_TICK, 1000, 1000, 1000, 1300, 1, 360, 1080, 30000));
		drive_tick(tick_of(MODE_TICK, 1000, 1000, 1000, 1305, 1, 360, 1080, 12000));
		drive_tick(tick_of(MODE_TICK, 1000, 1000, 1000, 1310, 1, 360, 1080, -5));
		// forced ends, unknown time with the light sensor off, field extremes
		drive_tick(tick_of(MODE_FORCE_OPEN, 4095, 4095, 4095, 0, 0, 360, 1080, 0));
		drive_tick(tick_of(MODE_TICK, 4095, 4095, 4095, 1300, 0, 360, 1080, 30000));
		drive_tick(tick_of(MODE_FORCE_CLOSE, 0, 0, 0, 1300, 1, 360, 1080, 0));
		drive_tick(tick_of(MODE_SPARE, 4095, 0, 4095, 2047, 1, 2047, 2047, 21'h0FFFFF));
		drive_tick(tick_of(MODE_SPARE, 0, 4095, 0, 1439, 1, 0, 0, 21'h100000));
		drive_tick(tick_of(MODE_TICK, 0, 4095, 0, 0, 1, 0, 0, 3000));
		drive_tick(tick_of(MODE_FORCE_OPEN, 0, 4095, 0, 0, 1, 0, 0, 6000));
		// stall: untracked close with a frozen encoder
		settle();
		write_reg(REG_TRACKING, 0);
		drive_tick(tick_of(MODE_TICK, 100, 100, 100, 1300, 1, 360, 1080, 30000));
		drive_tick(tick_of(MODE_TICK, 100, 100, 100, 1301, 1, 360, 1080, 30000));
		// between ends: tracking back on with a taller top leaves the door midway
		settle();
		write_reg(REG_TRACKING, 1);
		write_reg(REG_TOP_POSITION, 20);
		drive_tick(tick_of(MODE_TICK, 100, 100, 100, 600, 1, 360, 1080, 30000));
		drive_tick(tick_of(MODE_TICK, 100, 100, 100, 601, 1, 360, 1080, 0));
		// light alone decides
		settle();
		write_reg(REG_LIGHT_ENABLE, 1);
		write_reg(REG_TIME_ENABLE, 0);
		drive_tick(tick_of(MODE_TICK, 4095, 4095, 4095, 100, 0, 360, 1080, 60000));
		drive_tick(tick_of(MODE_TICK, 0, 0, 0, 700, 1, 360, 1080, 0));

		// Random phases, each under its own register setting
		for (phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0: apply_setting(37, 25, 10, 0, 1, 1, 1, 1);
				1: apply_setting(200, 100, 5, 130, 1, 1, 0, 1);
				2: apply_setting(37, 25, 8, 50, 1, 0, 1, 0);
				3: apply_setting(0, 255, 1, 255, 1, 1, 1, 1);
				4: apply_setting(255, 0, 254, 99, 1, 1, 1, 0);
				5: apply_setting(30, 30, 0, 100, 1, 1, 1, 1);
				6: apply_setting(40, 20, 255, 125, 0, 1, 1, 1);
				7: apply_setting(37, 25, 3, 126, 1, 0, 0, 1);
				default: apply_setting(pick_byte(), pick_byte(), $urandom_range(1, 30),
					pick_byte(), $urandom_range(0, 3) != 0, $urandom_range(0, 1) != 0,
					$urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
			endcase
			settings_run++;
			for (k = 0; k < TICKS_PER_PHASE; k++) begin
				if (k % 25 == 0)
					calm = ($urandom_range(0, 3) == 0);
				// hold the sender mid-phase until the block has nothing in flight
				if (k == 40)
					drain();
				drive_tick(roll_tick());
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("%0d ticks checked under %0d register settings, %0d register writes",
			ticks_checked, settings_run, reg_writes);
		$display("%0d moves finished, %0d of them on a stalled encoder", moves_finished,
			stalls_seen);
		if (error_count == 0)
			$display("light_time_door_controller regression: pass");
		else
			$display("light_time_door_controller regression: fail");
		$finish;
	end

endmodule
